// File: rtl/core/pts_pkg.sv
`timescale 1ns / 1ps

package pts_pkg;

   localparam int MAX_TASKS = 16;
   localparam int IDX_W     = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;

   localparam int REQ_DATA_W = 56;
   localparam int REQ_USER_W = 2;
   localparam int RSP_DATA_W = 32;

   typedef enum logic [1:0] {
      FN_TICK     = 2'd0,
      FN_ADD      = 2'd1,
      FN_DELETE   = 2'd2,
      FN_DISPATCH = 2'd3
   } func_type;

   typedef enum logic [2:0] {
      ST_DONE     = 3'd0,
      ST_FULL     = 3'd1,
      ST_NO_TASK  = 3'd2,
      ST_DUE      = 3'd3,
      ST_NONE_DUE = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      ERR_NONE   = 2'd0,
      ERR_FULL   = 2'd1,
      ERR_DELETE = 2'd2
   } error_type;

   typedef enum logic [2:0] {
      SEQ_IDLE,
      SEQ_TICK,
      SEQ_ADD,
      SEQ_DELETE,
      SEQ_DISPATCH,
      SEQ_EMIT
   } seq_type;

endpackage

// File: rtl/core/periodic_task_tick_scheduler.sv
`timescale 1ns / 1ps
// Channel   Direction  Payload
// req_      in         tuser: func; tdata: slot, task_handle, first_delay, period
// rsp_      out        tdata: status, slot_index, due_handle, error_code; tlast: last
//
// A sequencer walks the slot table one slot per cycle through a single update path,
// except while dispatch holds on rsp_. Tick and dispatch walk every slot, add stops at
// the first free slot, delete visits only the named slot; each ends with a result.
// One item at a time: req_tready is high only between items. The result register
// frees the walk from rsp_tready except when a second due task meets a full register.
// Reset clears busy marks, sticky error and all control state.

module periodic_task_tick_scheduler
   import pts_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  req_tvalid,
   output logic                  req_tready,
   // [1:0] func
   input  logic [REQ_USER_W-1:0] req_tuser,
   // [7:0] slot, [23:8] task_handle, [39:24] first_delay, [55:40] period
   input  logic [REQ_DATA_W-1:0] req_tdata,

   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [2:0] status, [7:3] slot_index, [23:8] due_handle, [25:24] error_code, rest zero
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tlast
);

   // slot table
   logic        busy_ff   [MAX_TASKS];
   logic [15:0] handle_ff [MAX_TASKS];
   logic [15:0] delay_ff  [MAX_TASKS];
   logic [15:0] period_ff [MAX_TASKS];
   logic [7:0]  runs_ff   [MAX_TASKS];

   // latched item
   logic [7:0]  slot_ff;
   logic [15:0] new_handle_ff, first_ff, new_period_ff;

   seq_type     state_ff, state_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   error_type   sticky_ff, sticky_in;

   logic        pend_valid_ff, pend_valid_in;
   status_type  pend_status_ff, pend_status_in;
   logic [4:0]  pend_idx_ff, pend_idx_in;
   logic [15:0] pend_handle_ff, pend_handle_in;

   logic        rsp_valid_ff;
   status_type  rsp_status_ff;
   logic [4:0]  rsp_idx_ff;
   logic [15:0] rsp_handle_ff;
   error_type   rsp_error_ff;
   logic        rsp_last_ff;

   logic        push, push_last;
   logic        req_xfer, out_free, at_end;
   logic        ent_add, ent_busy_clr, ent_delay_we, ent_runs_we;
   logic [15:0] ent_delay_in;
   logic [7:0]  ent_runs_in;

   logic        cur_busy;
   logic [15:0] cur_delay, cur_period;
   logic [7:0]  cur_runs;
   logic        cur_due;
   func_type    req_func;

   assign cur_busy   = busy_ff[idx_ff];
   assign cur_delay  = delay_ff[idx_ff];
   assign cur_period = period_ff[idx_ff];
   assign cur_runs   = runs_ff[idx_ff];
   assign cur_due    = cur_busy && (cur_runs != 8'd0);

   assign req_func   = func_type'(req_tuser[1:0]);
   assign req_tready = (state_ff == SEQ_IDLE);
   assign req_xfer   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign at_end     = (idx_ff == IDX_W'(MAX_TASKS - 1));

   always_comb begin
      state_in       = state_ff;
      idx_in         = idx_ff;
      sticky_in      = sticky_ff;
      pend_valid_in  = pend_valid_ff;
      pend_status_in = pend_status_ff;
      pend_idx_in    = pend_idx_ff;
      pend_handle_in = pend_handle_ff;
      push           = 1'b0;
      push_last      = 1'b1;
      ent_add        = 1'b0;
      ent_busy_clr   = 1'b0;
      ent_delay_we   = 1'b0;
      ent_delay_in   = cur_delay;
      ent_runs_we    = 1'b0;
      ent_runs_in    = cur_runs;

      case (state_ff)
         SEQ_IDLE: begin
            if (req_xfer) begin
               pend_valid_in = 1'b0;
               idx_in        = '0;
               case (req_func)
                  FN_TICK:     state_in = SEQ_TICK;
                  FN_ADD:      state_in = SEQ_ADD;
                  FN_DELETE: begin
                     state_in = SEQ_DELETE;
                     idx_in   = req_tdata[IDX_W-1:0];
                  end
                  FN_DISPATCH: state_in = SEQ_DISPATCH;
                  default:     state_in = SEQ_IDLE;
               endcase
            end
         end

         SEQ_TICK: begin
            if (cur_busy) begin
               if (cur_delay == 16'd0) begin
                  if (cur_runs != 8'hFF) begin
                     ent_runs_we = 1'b1;
                     ent_runs_in = cur_runs + 8'd1;
                  end
                  if (cur_period != 16'd0) begin
                     ent_delay_we = 1'b1;
                     ent_delay_in = cur_period;
                  end
               end else begin
                  ent_delay_we = 1'b1;
                  ent_delay_in = cur_delay - 16'd1;
               end
            end
            if (at_end) begin
               pend_status_in = ST_DONE;
               pend_idx_in    = '0;
               pend_handle_in = '0;
               state_in       = SEQ_EMIT;
            end else begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end

         SEQ_ADD: begin
            if (!cur_busy) begin
               ent_add        = 1'b1;
               pend_status_in = ST_DONE;
               pend_idx_in    = 5'(idx_ff);
               pend_handle_in = '0;
               state_in       = SEQ_EMIT;
            end else if (at_end) begin
               sticky_in      = ERR_FULL;
               pend_status_in = ST_FULL;
               pend_idx_in    = 5'(MAX_TASKS);
               pend_handle_in = '0;
               state_in       = SEQ_EMIT;
            end else begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end

         SEQ_DELETE: begin
            // range check first; the busy mark read at the low slot bits counts only for a valid slot
            pend_idx_in    = slot_ff[4:0];
            pend_handle_in = '0;
            state_in       = SEQ_EMIT;
            if ((slot_ff >= 8'(MAX_TASKS)) || !cur_busy) begin
               sticky_in      = ERR_DELETE;
               pend_status_in = ST_NO_TASK;
            end else begin
               ent_busy_clr   = 1'b1;
               pend_status_in = ST_DONE;
            end
         end

         SEQ_DISPATCH: begin
            if (cur_due && pend_valid_ff && !out_free) begin
               // hold: the earlier due task cannot leave yet
               state_in = SEQ_DISPATCH;
            end else begin
               if (cur_due) begin
                  if (pend_valid_ff) begin
                     push      = 1'b1;
                     push_last = 1'b0;
                  end
                  ent_runs_we    = 1'b1;
                  ent_runs_in    = cur_runs - 8'd1;
                  ent_busy_clr   = (cur_period == 16'd0);
                  pend_valid_in  = 1'b1;
                  pend_status_in = ST_DUE;
                  pend_idx_in    = 5'(idx_ff);
                  pend_handle_in = handle_ff[idx_ff];
               end
               if (at_end) begin
                  state_in = SEQ_EMIT;
                  if (!cur_due && !pend_valid_ff) begin
                     pend_status_in = ST_NONE_DUE;
                     pend_idx_in    = '0;
                     pend_handle_in = '0;
                  end
               end else begin
                  idx_in = idx_ff + IDX_W'(1);
               end
            end
         end

         SEQ_EMIT: begin
            if (out_free) begin
               push      = 1'b1;
               push_last = 1'b1;
               state_in  = SEQ_IDLE;
            end
         end

         default: state_in = SEQ_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= SEQ_IDLE;
         idx_ff        <= '0;
         sticky_ff     <= ERR_NONE;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         idx_ff        <= idx_in;
         sticky_ff     <= sticky_in;
         pend_valid_ff <= pend_valid_in;
         if (push) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      pend_status_ff <= pend_status_in;
      pend_idx_ff    <= pend_idx_in;
      pend_handle_ff <= pend_handle_in;
      if (req_xfer) begin
         slot_ff       <= req_tdata[7:0];
         new_handle_ff <= req_tdata[23:8];
         first_ff      <= req_tdata[39:24];
         new_period_ff <= req_tdata[55:40];
      end
      if (push) begin
         rsp_status_ff <= pend_status_ff;
         rsp_idx_ff    <= pend_idx_ff;
         rsp_handle_ff <= pend_handle_ff;
         rsp_error_ff  <= sticky_ff;
         rsp_last_ff   <= push_last;
      end
   end

   // busy marks are the only table state that needs reset
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_TASKS; i++) begin
            busy_ff[i] <= 1'b0;
         end
      end else if (ent_add) begin
         busy_ff[idx_ff] <= 1'b1;
      end else if (ent_busy_clr) begin
         busy_ff[idx_ff] <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ent_add) begin
         handle_ff[idx_ff] <= new_handle_ff;
         delay_ff[idx_ff]  <= first_ff;
         period_ff[idx_ff] <= new_period_ff;
         runs_ff[idx_ff]   <= 8'd0;
      end else begin
         if (ent_delay_we) begin
            delay_ff[idx_ff] <= ent_delay_in;
         end
         if (ent_runs_we) begin
            runs_ff[idx_ff] <= ent_runs_in;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {6'd0, rsp_error_ff, rsp_handle_ff, rsp_idx_ff, rsp_status_ff};

endmodule

// File: rtl/core/pts_checker.sv
`timescale 1ns / 1ps

module pts_checker
   import pts_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic                  rsp_tlast
);

   logic err_seen_ff;

   // remember that a nonzero error code has been shown
   always_ff @(posedge clock) begin
      if (reset) begin
         err_seen_ff <= 1'b0;
      end else if (rsp_tvalid && rsp_tready && (rsp_tdata[25:24] != ERR_NONE)) begin
         err_seen_ff <= 1'b1;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("result changed while stalled");

   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second item taken while one is at work");

   a_single_result: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[2:0] != ST_DUE) |-> rsp_tlast)
      else $error("non-dispatch result not marked final");

   a_sticky: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && err_seen_ff |-> (rsp_tdata[25:24] != ERR_NONE))
      else $error("sticky error cleared");

endmodule

bind periodic_task_tick_scheduler pts_checker u_pts_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
